// ===== hdl/jq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Job queue package
// Sizes, slot and result record types, outcome codes and controller states.
// ----------------------------------------------------------------------------
package jq_pkg;

  localparam int QUEUE_DEPTH = 3;
  localparam int TIME_WIDTH  = 32;
  localparam int ID_WIDTH    = 16;

  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W = $clog2(2 * QUEUE_DEPTH);

  typedef logic [TIME_WIDTH-1:0] time_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  typedef enum logic [1:0] {
    OC_DONE     = 2'd0,
    OC_EXP_HEAD = 2'd1,
    OC_EXP_RUN  = 2'd2,
    OC_REJECT   = 2'd3
  } outcome_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_RUN,
    ST_DRAIN
  } state_e;

  typedef struct packed {
    logic [ID_WIDTH-1:0] id;
    time_t               arr;
    time_t               len;
    time_t               dl;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

  typedef struct packed {
    logic [ID_WIDTH-1:0] id;
    outcome_e            outcome;
    time_t               event_time;
    time_t               wait_delay;
    logic                last;
  } result_t;

endpackage

// ===== hdl/jq_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Job queue channel interfaces
// Arriving job channel and result record channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface jq_job_if;
  logic                          valid;
  logic                          ready;
  logic [jq_pkg::ID_WIDTH-1:0]   job_id;
  logic [jq_pkg::TIME_WIDTH-1:0] arrival_time;
  logic [jq_pkg::TIME_WIDTH-1:0] run_length;
  logic [jq_pkg::TIME_WIDTH-1:0] deadline;
  logic                          final_job;

  modport source (output valid, job_id, arrival_time, run_length, deadline, final_job,
                  input ready);
  modport sink (input valid, job_id, arrival_time, run_length, deadline, final_job,
                output ready);
endinterface

interface jq_res_if;
  logic                          valid;
  logic                          ready;
  logic [jq_pkg::ID_WIDTH-1:0]   job_id_res;
  logic [1:0]                    outcome;
  logic [jq_pkg::TIME_WIDTH-1:0] event_time;
  logic [jq_pkg::TIME_WIDTH-1:0] wait_delay;
  logic                          last_result;

  modport source (output valid, job_id_res, outcome, event_time, wait_delay, last_result,
                  input ready);
  modport sink (input valid, job_id_res, outcome, event_time, wait_delay, last_result,
                output ready);
endinterface

// ===== hdl/jq_slot_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Job queue slot RAM
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module jq_slot_ram #(
  parameter int DEPTH  = 3,
  parameter int WIDTH  = 8,
  parameter int ADDR_W = 2
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/jq_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Job queue controller
// Admission, head retirement and drain sequencing around the slot RAM.
// ----------------------------------------------------------------------------
module jq_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  jq_pkg::slot_t                in_job_i,
  input  logic                         in_final_i,
  output logic                         emit_o,
  output jq_pkg::result_t              rec_o,
  input  logic                         out_free_i,
  output logic                         we_o,
  output jq_pkg::idx_t                 waddr_o,
  output jq_pkg::slot_t                wdata_o,
  output logic                         re_o,
  output jq_pkg::idx_t                 raddr_o,
  input  jq_pkg::slot_t                rdata_i
);

  jq_pkg::state_e state_q, state_d;
  jq_pkg::slot_t  job_q, job_d;
  logic           final_q, final_d;
  logic           drain_q, drain_d;
  jq_pkg::time_t  free_q, free_d;
  jq_pkg::idx_t   head_q, head_d;
  jq_pkg::cnt_t   count_q, count_d;

  logic [jq_pkg::SUM_W-1:0]      tail_sum;
  jq_pkg::idx_t                  tail;
  jq_pkg::idx_t                  head_inc;
  jq_pkg::cnt_t                  count_dec;
  logic [jq_pkg::TIME_WIDTH:0]   fin;
  logic                          exp_head;
  logic                          fits;
  jq_pkg::time_t                 free_after;
  logic                          pre_run;

  always_comb begin
    tail_sum = jq_pkg::SUM_W'(head_q) + jq_pkg::SUM_W'(count_q);
    if (tail_sum >= jq_pkg::SUM_W'(jq_pkg::QUEUE_DEPTH)) begin
      tail_sum = tail_sum - jq_pkg::SUM_W'(jq_pkg::QUEUE_DEPTH);
    end
    tail      = tail_sum[jq_pkg::IDX_W-1:0];
    head_inc  = (head_q == jq_pkg::IDX_W'(jq_pkg::QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
    count_dec = count_q - 1'b1;
    pre_run   = (count_q != '0) && (free_q < job_q.arr);
    // Finish time carries one extra bit so that it never wraps.
    fin       = {1'b0, free_q} + {1'b0, rdata_i.len};
    exp_head  = free_q >= rdata_i.dl;
    fits      = fin <= {1'b0, rdata_i.dl};
    if (exp_head) begin
      free_after = free_q;
    end else if (fits) begin
      free_after = fin[jq_pkg::TIME_WIDTH-1:0];
    end else begin
      free_after = rdata_i.dl;
    end
  end

  always_comb begin
    state_d    = state_q;
    job_d      = job_q;
    final_d    = final_q;
    drain_d    = drain_q;
    free_d     = free_q;
    head_d     = head_q;
    count_d    = count_q;
    in_ready_o = 1'b0;
    emit_o     = 1'b0;
    rec_o      = '0;
    we_o       = 1'b0;
    waddr_o    = tail;
    wdata_o    = job_q;
    re_o       = 1'b0;
    raddr_o    = head_q;
    case (state_q)
      jq_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          job_d   = in_job_i;
          final_d = in_final_i;
          state_d = jq_pkg::ST_CHECK;
        end
      end
      jq_pkg::ST_CHECK: begin
        if (pre_run) begin
          re_o    = 1'b1;
          state_d = jq_pkg::ST_RUN;
        end else begin
          if ((count_q == '0) && (free_q < job_q.arr)) begin
            free_d = job_q.arr;
          end
          if (count_q < jq_pkg::CNT_W'(jq_pkg::QUEUE_DEPTH)) begin
            we_o    = 1'b1;
            count_d = count_q + 1'b1;
            drain_d = final_q;
            state_d = final_q ? jq_pkg::ST_DRAIN : jq_pkg::ST_IDLE;
          end else begin
            emit_o           = 1'b1;
            rec_o.id         = job_q.id;
            rec_o.outcome    = jq_pkg::OC_REJECT;
            rec_o.event_time = job_q.arr;
            rec_o.wait_delay = '0;
            rec_o.last       = !final_q;
            if (out_free_i) begin
              drain_d = final_q;
              state_d = final_q ? jq_pkg::ST_DRAIN : jq_pkg::ST_IDLE;
            end
          end
        end
      end
      jq_pkg::ST_RUN: begin
        emit_o   = 1'b1;
        rec_o.id = rdata_i.id;
        if (exp_head) begin
          rec_o.outcome    = jq_pkg::OC_EXP_HEAD;
          rec_o.event_time = free_q;
          rec_o.wait_delay = free_q - rdata_i.arr;
        end else if (fits) begin
          rec_o.outcome    = jq_pkg::OC_DONE;
          rec_o.event_time = fin[jq_pkg::TIME_WIDTH-1:0];
          rec_o.wait_delay = free_q - rdata_i.arr;
        end else begin
          rec_o.outcome    = jq_pkg::OC_EXP_RUN;
          rec_o.event_time = rdata_i.dl;
          rec_o.wait_delay = rdata_i.dl - rdata_i.arr;
        end
        // Before admission the new job is still to come, so only a drain
        // can end the input on an empty queue.
        if (drain_q) begin
          rec_o.last = (count_dec == '0);
        end else begin
          rec_o.last = !final_q && !((count_dec != '0) && (free_after < job_q.arr));
        end
        if (out_free_i) begin
          free_d  = free_after;
          head_d  = head_inc;
          count_d = count_dec;
          state_d = drain_q ? jq_pkg::ST_DRAIN : jq_pkg::ST_CHECK;
        end
      end
      jq_pkg::ST_DRAIN: begin
        if (count_q != '0) begin
          re_o    = 1'b1;
          state_d = jq_pkg::ST_RUN;
        end else begin
          drain_d = 1'b0;
          state_d = jq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = jq_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= jq_pkg::ST_IDLE;
      drain_q <= 1'b0;
      free_q  <= '0;
      head_q  <= '0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      drain_q <= drain_d;
      free_q  <= free_d;
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q   <= job_d;
    final_q <= final_d;
  end

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= jq_pkg::CNT_W'(jq_pkg::QUEUE_DEPTH))
    else $error("waiting count beyond queue depth");

  a_no_rw_overlap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(we_o && re_o))
    else $error("slot write and read in the same cycle");

  a_read_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    re_o |-> (count_q != '0))
    else $error("slot read from an empty queue");

  a_read_then_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    re_o |=> (state_q == jq_pkg::ST_RUN))
    else $error("slot read not followed by retirement");

  a_last_drain_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == jq_pkg::ST_RUN && drain_q && emit_o && out_free_i && rec_o.last)
      |=> ##1 (state_q == jq_pkg::ST_IDLE))
    else $error("drain did not end after its last record");

endmodule

// ===== hdl/fifo_job_queue_with_deadlines_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FIFO job queue with deadlines, top level
// Single-server scheduler: jobs wait in a bounded FIFO held in a slot RAM and
// are retired in order, each reported as done, expired or rejected.
//
// Sequence: an accepted job is examined in the following cycle; each retired head
// job takes a registered RAM read, then an evaluation that writes the result
// register and waits while that register is full. A new job is taken only after
// the previous one and the retirements and drain it caused are complete.
// Reset clears the server clock, head pointer and count; the slot RAM is not
// cleared, since only slots holding a waiting job are ever read.
// ----------------------------------------------------------------------------
module fifo_job_queue_with_deadlines_top (
  input  logic clk_i,
  input  logic rst_ni,
  jq_job_if.sink   job_i,
  jq_res_if.source res_o
);

  jq_pkg::slot_t   in_job;
  jq_pkg::slot_t   wdata;
  jq_pkg::slot_t   rdata;
  jq_pkg::idx_t    waddr;
  jq_pkg::idx_t    raddr;
  jq_pkg::result_t rec;
  jq_pkg::result_t res_q;
  logic            we;
  logic            re;
  logic            emit;
  logic            out_free;
  logic            res_valid_q, res_valid_d;

  // Pack the arriving job into the slot layout used by the RAM.
  assign in_job.id  = job_i.job_id;
  assign in_job.arr = job_i.arrival_time;
  assign in_job.len = job_i.run_length;
  assign in_job.dl  = job_i.deadline;

  jq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (job_i.valid),
    .in_ready_o (job_i.ready),
    .in_job_i   (in_job),
    .in_final_i (job_i.final_job),
    .emit_o     (emit),
    .rec_o      (rec),
    .out_free_i (out_free),
    .we_o       (we),
    .waddr_o    (waddr),
    .wdata_o    (wdata),
    .re_o       (re),
    .raddr_o    (raddr),
    .rdata_i    (rdata)
  );

  jq_slot_ram #(
    .DEPTH  (jq_pkg::QUEUE_DEPTH),
    .WIDTH  (jq_pkg::SLOT_W),
    .ADDR_W (jq_pkg::IDX_W)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // The result register can take a new record when it is empty or when its
  // current record is being transferred in this cycle.
  assign out_free = !res_valid_q || res_o.ready;

  always_comb begin
    res_valid_d = res_valid_q;
    if (emit && out_free) begin
      res_valid_d = 1'b1;
    end else if (res_o.ready) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit && out_free) begin
      res_q <= rec;
    end
  end

  assign res_o.valid       = res_valid_q;
  assign res_o.job_id_res  = res_q.id;
  assign res_o.outcome     = res_q.outcome;
  assign res_o.event_time  = res_q.event_time;
  assign res_o.wait_delay  = res_q.wait_delay;
  assign res_o.last_result = res_q.last;

endmodule

// ===== test/jq_sched_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Job queue scoreboard
// Watches the job and result channels, keeps its own copy of the scheduler
// state, predicts the records of every job transfer and compares each result
// transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module jq_sched_checker (
  input  logic clk_i,
  input  logic rst_ni,
  jq_job_if    job,
  jq_res_if    res,
  output int   mismatch_cnt_o,
  output int   pending_o
);

  jq_pkg::time_t   busy_until = '0;
  jq_pkg::slot_t   queue_slots [jq_pkg::QUEUE_DEPTH];
  int              head_ix = 0;
  int              queued = 0;
  int              mismatches = 0;
  jq_pkg::result_t expected_records [$];

  assign mismatch_cnt_o = mismatches;
  assign pending_o      = expected_records.size();

  task automatic post_record(input logic [jq_pkg::ID_WIDTH-1:0] id,
                             input jq_pkg::outcome_e oc,
                             input jq_pkg::time_t t, input jq_pkg::time_t d);
    jq_pkg::result_t rec;
    rec.id         = id;
    rec.outcome    = oc;
    rec.event_time = t;
    rec.wait_delay = d;
    rec.last       = 1'b0;
    expected_records = {expected_records, rec};
  endtask

  // Serve the oldest waiting job at the current server time.
  task automatic retire_head();
    jq_pkg::slot_t               s;
    jq_pkg::time_t               now;
    logic [jq_pkg::TIME_WIDTH:0] finish;
    s       = queue_slots[head_ix];
    now     = busy_until;
    head_ix = (head_ix + 1) % jq_pkg::QUEUE_DEPTH;
    queued--;
    if (now >= s.dl) begin
      post_record(s.id, jq_pkg::OC_EXP_HEAD, now, now - s.arr);
    end else begin
      // Finish time kept one bit wider so that it cannot wrap.
      finish = {1'b0, now} + {1'b0, s.len};
      if (finish <= {1'b0, s.dl}) begin
        post_record(s.id, jq_pkg::OC_DONE, finish[jq_pkg::TIME_WIDTH-1:0], now - s.arr);
        busy_until = finish[jq_pkg::TIME_WIDTH-1:0];
      end else begin
        post_record(s.id, jq_pkg::OC_EXP_RUN, s.dl, s.dl - s.arr);
        busy_until = s.dl;
      end
    end
  endtask

  task automatic schedule_job(input jq_pkg::slot_t j, input logic drain);
    int n_before;
    n_before = expected_records.size();
    while (queued > 0 && busy_until < j.arr) begin
      retire_head();
    end
    if (queued == 0 && busy_until < j.arr) begin
      busy_until = j.arr;
    end
    if (queued < jq_pkg::QUEUE_DEPTH) begin
      queue_slots[(head_ix + queued) % jq_pkg::QUEUE_DEPTH] = j;
      queued++;
    end else begin
      post_record(j.id, jq_pkg::OC_REJECT, j.arr, '0);
    end
    if (drain) begin
      while (queued > 0) begin
        retire_head();
      end
    end
    if (expected_records.size() > n_before) begin
      expected_records[expected_records.size() - 1].last = 1'b1;
    end
  endtask

  task automatic check_record();
    jq_pkg::result_t want;
    if (expected_records.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: unexpected record id=%h oc=%0d ev=%h wd=%h last=%b", $realtime,
                 res.job_id_res, res.outcome, res.event_time, res.wait_delay,
                 res.last_result);
      end
    end else begin
      want = expected_records.pop_front();
      if (res.job_id_res !== want.id || res.outcome !== want.outcome ||
          res.event_time !== want.event_time || res.wait_delay !== want.wait_delay ||
          res.last_result !== want.last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: record mismatch, expected id=%h oc=%0d ev=%h wd=%h last=%b",
                   $realtime, want.id, want.outcome, want.event_time, want.wait_delay,
                   want.last);
          $display("%0t:                  actual   id=%h oc=%0d ev=%h wd=%h last=%b",
                   $realtime, res.job_id_res, res.outcome, res.event_time,
                   res.wait_delay, res.last_result);
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_until = '0;
      head_ix    = 0;
      queued     = 0;
      expected_records.delete();
    end else begin
      // Records are registered, so a result transfer never belongs to a job
      // taken at the same edge; checking it first is safe.
      if (res.valid && res.ready) begin
        check_record();
      end
      if (job.valid && job.ready) begin
        schedule_job('{id: job.job_id, arr: job.arrival_time, len: job.run_length,
                       dl: job.deadline}, job.final_job);
      end
    end
  end

endmodule

// ===== test/fifo_job_queue_with_deadlines_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FIFO job queue with deadlines, testbench
// Drives a directed set of jobs and then a long random stream of jobs into the
// scheduler, with random idle cycles on both channels, a long result stall and
// a full pause of the job stream. A separate scoreboard predicts every record.
// ----------------------------------------------------------------------------
module fifo_job_queue_with_deadlines_top_tb;

  // Stimulus plan, counted in job transfers.
  localparam int RANDOM_JOBS    = 394;
  localparam int HOLD_AT        = 100;  // result side stalls here for a long time
  localparam int HOLD_CYCLES    = 150;
  localparam int DRAIN_PAUSE_AT = 220;  // job side waits for every record here
  localparam int QUIET_FROM     = 300;  // no idling on either side in this window
  localparam int QUIET_TO       = 360;
  localparam int LIMIT_CYCLES   = 200000;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  int sent_cnt = 0;
  int cycle_cnt = 0;
  int mismatches;
  int pending;

  jq_job_if job_ch ();
  jq_res_if res_ch ();

  fifo_job_queue_with_deadlines_top u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .job_i  (job_ch),
    .res_o  (res_ch)
  );

  jq_sched_checker u_chk (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .job            (job_ch),
    .res            (res_ch),
    .mismatch_cnt_o (mismatches),
    .pending_o      (pending)
  );

  always #5 clk_i = ~clk_i;

  // Watchdog: the slowest legal run is far below this limit.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic logic quiet_window();
    return sent_cnt >= QUIET_FROM && sent_cnt < QUIET_TO;
  endfunction

  // Result side. Each step makes exactly one assignment to ready, so ready is
  // never lowered and raised within the same step. The long hold-off is
  // counted in cycles here while the job side keeps offering, which fills the
  // queue and the result register and backs up the job channel.
  initial begin
    int  hold_left;
    logic hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else if (!hold_done && sent_cnt >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        res_ch.ready <= 1'b0;
      end else if (quiet_window()) begin
        res_ch.ready <= 1'b1;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= 38);
      end
    end
  end

  // Offer one job and hold it until the transfer. Idle cycles come before the
  // job, so valid stays high from one transfer to the next when there is none.
  task automatic send_job(input logic [jq_pkg::ID_WIDTH-1:0] id, input jq_pkg::time_t arr,
                          input jq_pkg::time_t len, input jq_pkg::time_t dl,
                          input logic last);
    int gap;
    gap = 0;
    if (sent_cnt == DRAIN_PAUSE_AT) begin
      // Let the block run dry: every predicted record has to come out first.
      job_ch.valid <= 1'b0;
      @(posedge clk_i);
      while (pending != 0) @(posedge clk_i);
    end else if (!quiet_window()) begin
      while ($urandom_range(99) < 38) gap++;
    end
    if (gap > 0) begin
      job_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    job_ch.valid        <= 1'b1;
    job_ch.job_id       <= id;
    job_ch.arrival_time <= arr;
    job_ch.run_length   <= len;
    job_ch.deadline     <= dl;
    job_ch.final_job    <= last;
    @(posedge clk_i);
    while (!job_ch.ready) @(posedge clk_i);
    sent_cnt++;
  endtask

  // Random jobs. Arrivals mostly creep forward from a base that now and then
  // jumps by a large amount, so the server clock sweeps the whole time range
  // while staying below the closing jobs. Runs of dense arrivals with longer
  // jobs fill the queue and cause rejections; sparse runs let it drain.
  task automatic send_random_jobs(input int count);
    jq_pkg::time_t base;
    jq_pkg::time_t arr;
    jq_pkg::time_t len;
    jq_pkg::time_t dl;
    int            r;
    logic          dense;
    logic          dl_set;
    base  = 32'd300;
    dense = 1'b0;
    for (int i = 0; i < count; i++) begin
      if (i % 24 == 0) dense = ($urandom_range(99) < 45);
      if (i % 50 == 49 && base < 32'hD000_0000) begin
        base += $urandom_range(32'h1000_0000, 32'h1C00_0000);
      end
      base += dense ? $urandom_range(0, 3) : $urandom_range(0, 40);
      arr = base;
      // A few jobs arrive earlier than the one before them.
      if ($urandom_range(99) < 4 && base > 32'd300) arr = base - $urandom_range(1, 300);
      dl_set = 1'b0;
      r = $urandom_range(99);
      if (r < 6) begin
        // Any length, but with a near deadline, so the clock cannot run away.
        len    = $urandom;
        dl     = arr + $urandom_range(0, 60);
        dl_set = 1'b1;
      end else begin
        len = dense ? $urandom_range(2, 30) : $urandom_range(0, 25);
      end
      if (!dl_set) begin
        r = $urandom_range(99);
        if (r < 8) begin
          dl = $urandom;
        end else if (r < 16) begin
          dl = (arr > 32'd20) ? arr - $urandom_range(1, 20) : '0;
        end else if (r < 20) begin
          dl = '1;
        end else begin
          dl = arr + $urandom_range(0, 120);
        end
      end
      send_job(jq_pkg::ID_WIDTH'($urandom_range(0, 16'hFFFF)), arr, len, dl,
               $urandom_range(99) < 7);
    end
  endtask

  initial begin
    job_ch.valid        <= 1'b0;
    job_ch.job_id       <= '0;
    job_ch.arrival_time <= '0;
    job_ch.run_length   <= '0;
    job_ch.deadline     <= '0;
    job_ch.final_job    <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed jobs. The first one moves the idle server clock up to its
    // arrival; a zero length job with the largest deadline and one with a
    // zero deadline follow, the lowest and highest ids among them.
    send_job(16'h0000, 32'd10, 32'd5, 32'd100, 1'b0);
    send_job(16'hFFFF, 32'd10, 32'd0, 32'hFFFF_FFFF, 1'b0);
    send_job(16'h0002, 32'd11, 32'd3, 32'd0, 1'b0);
    // Queue full, then a rejected job with an earlier arrival that also asks
    // for the drain: it yields the most records one job can cause, with a
    // job expiring at the head and one finishing exactly at its deadline.
    send_job(16'h0003, 32'd12, 32'd7, 32'd22, 1'b0);
    send_job(16'h0004, 32'd13, 32'd1, 32'd50, 1'b0);
    send_job(16'h0005, 32'd12, 32'd1, 32'd50, 1'b1);
    // Expiry while running, once with a finish beyond the time range, and a
    // head job whose deadline equals the server time.
    send_job(16'h0006, 32'd30, 32'd10, 32'd35, 1'b0);
    send_job(16'h0007, 32'd30, 32'hFFFF_FFFF, 32'd45, 1'b0);
    send_job(16'h0008, 32'd31, 32'd5, 32'd40, 1'b0);
    send_job(16'h0009, 32'd50, 32'd1, 32'd50, 1'b1);
    // A lone final job, then an arrival behind the server clock.
    send_job(16'h00AA, 32'd60, 32'd5, 32'hFFFF_FFFF, 1'b1);
    send_job(16'h5555, 32'd60, 32'h7FFF_FFFF, 32'd200, 1'b0);
    send_job(16'h1234, 32'd70, 32'd20, 32'h7FFF_FFFF, 1'b1);

    send_random_jobs(RANDOM_JOBS);

    // Closing jobs at the very top of the time range: a finish that lands on
    // the largest time, then jobs that find the clock at their deadline.
    send_job(16'hA5A5, 32'hFFFF_FFF0, 32'h0000_000F, 32'hFFFF_FFFF, 1'b0);
    send_job(16'h5A5A, 32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF, 1'b0);
    send_job(16'hFFFE, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 1'b1);
    job_ch.valid <= 1'b0;

    // Wait for every predicted record, then a few more cycles so that a stray
    // extra record would still be seen.
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (2 * jq_pkg::QUEUE_DEPTH + 8) @(posedge clk_i);

    if (mismatches == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== fifo_job_queue_with_deadlines_top.f =====
hdl/jq_pkg.sv
hdl/jq_if.sv
hdl/jq_slot_ram.sv
hdl/jq_ctrl.sv
hdl/fifo_job_queue_with_deadlines_top.sv
test/jq_sched_checker.sv
test/fifo_job_queue_with_deadlines_top_tb.sv
